### src/sbrs_pkg.sv
// ----------------------------------------------------------------------------
// sbrs_pkg
// Shared types and constants for the sprite blitter.
// ----------------------------------------------------------------------------
package sbrs_pkg;

    localparam int IMAGE_WIDTH_DEF  = 64;
    localparam int IMAGE_HEIGHT_DEF = 64;
    localparam int MEM_DEPTH        = 4096;
    localparam int ADDR_W           = 12;
    localparam int DIV_STEPS        = 8;
    localparam int CFG_IDX_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURNS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MONO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TINT    = 3'd7;

    localparam logic [31:0] WINDOW_RST  = 32'h4040_0000;
    localparam logic [15:0] SCALE_RST   = 16'h0100;
    localparam logic [8:0]  OPACITY_RST = 9'd256;
    localparam logic [63:0] PALETTE_RST = 64'hFFFF_FFFF_FF00_0000;
    localparam logic [7:0]  ALPHA_FULL  = 8'hFF;

    typedef struct packed {
        logic [31:0]        window;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [1:0]         turns;
    } geom_cfg_t;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [ADDR_W-1:0]  load_address;
        logic [31:0]        load_color;
        logic               ok;
        logic               odd;
        logic signed [16:0] tx;
        logic signed [16:0] ty;
        logic [16:0]        ru;
        logic [16:0]        rv;
        logic [7:0]         qu;
        logic [7:0]         qv;
    } map_stage_t;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic signed [16:0] tx;
        logic signed [16:0] ty;
    } pix_meta_t;

endpackage

### src/sbrs_map.sv
// ----------------------------------------------------------------------------
// sbrs_map
// Area check, target mirroring and pipelined source coordinate division.
// ----------------------------------------------------------------------------
module sbrs_map
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     accept,
    input  logic                     kind,
    input  logic [11:0]              load_address,
    input  logic [31:0]              load_color,
    input  logic signed [15:0]       dest_x,
    input  logic signed [15:0]       dest_y,
    input  logic [12:0]              step_i,
    input  logic [12:0]              step_j,
    input  sbrs_pkg::geom_cfg_t      cfg,
    output sbrs_pkg::map_stage_t     tail
);
    import sbrs_pkg::*;

    map_stage_t  stg_reg [0:DIV_STEPS];
    map_stage_t  head_next;
    logic [15:0] ax, ay, aw0, ah0, aw, ah, off_x, off_y;
    logic [23:0] pw, ph;
    logic [7:0]  ww, wh;
    logic        odd, fx, fy, in_area, ovf;

    always_comb
    begin
        ww   = cfg.window[23:16];
        wh   = cfg.window[31:24];
        ax   = cfg.scale_x[15] ? 16'(-cfg.scale_x) : cfg.scale_x;
        ay   = cfg.scale_y[15] ? 16'(-cfg.scale_y) : cfg.scale_y;
        pw   = 24'(ww) * 24'(ax);
        ph   = 24'(wh) * 24'(ay);
        aw0  = pw[23:8];
        ah0  = ph[23:8];
        odd  = cfg.turns[0];
        aw   = odd ? ah0 : aw0;
        ah   = odd ? aw0 : ah0;
        in_area = (ax != 16'd0) && (ay != 16'd0)
                  && ({3'b000, step_i} < aw) && ({3'b000, step_j} < ah);
        ovf  = ({3'b000, step_i} >= ax) || ({3'b000, step_j} >= ay);
        fx   = cfg.scale_x[15] ^ (cfg.turns == 2'd1 || cfg.turns == 2'd2);
        fy   = cfg.scale_y[15] ^ cfg.turns[1];
        off_x = fx ? 16'(aw - 16'd1 - {3'b000, step_i}) : {3'b000, step_i};
        off_y = fy ? 16'(ah - 16'd1 - {3'b000, step_j}) : {3'b000, step_j};

        head_next              = '0;
        head_next.valid        = accept;
        head_next.kind         = kind;
        head_next.load_address = load_address;
        head_next.load_color   = load_color;
        head_next.ok           = in_area && !ovf;
        head_next.odd          = odd;
        head_next.tx           = {dest_x[15], dest_x} + {1'b0, off_x};
        head_next.ty           = {dest_y[15], dest_y} + {1'b0, off_y};
        head_next.ru           = 17'(step_i);
        head_next.rv           = 17'(step_j);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg[0] <= '0;
        end
        else if (adv)
        begin
            stg_reg[0] <= head_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            map_stage_t  step_next;
            logic [16:0] r2u, r2v;
            always_comb
            begin
                step_next = stg_reg[k];
                r2u = {stg_reg[k].ru[15:0], 1'b0};
                r2v = {stg_reg[k].rv[15:0], 1'b0};
                if (r2u >= {1'b0, ax})
                begin
                    step_next.ru = r2u - {1'b0, ax};
                    step_next.qu = {stg_reg[k].qu[6:0], 1'b1};
                end
                else
                begin
                    step_next.ru = r2u;
                    step_next.qu = {stg_reg[k].qu[6:0], 1'b0};
                end
                if (r2v >= {1'b0, ay})
                begin
                    step_next.rv = r2v - {1'b0, ay};
                    step_next.qv = {stg_reg[k].qv[6:0], 1'b1};
                end
                else
                begin
                    step_next.rv = r2v;
                    step_next.qv = {stg_reg[k].qv[6:0], 1'b0};
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stg_reg[k+1] <= '0;
                end
                else if (adv)
                begin
                    stg_reg[k+1] <= step_next;
                end
            end
        end
    endgenerate

    assign tail = stg_reg[DIV_STEPS];

endmodule

### src/sbrs_mem.sv
// ----------------------------------------------------------------------------
// sbrs_mem
// Sprite memory: load writes and draw reads at one pipeline slot.
// ----------------------------------------------------------------------------
module sbrs_mem
#(
    parameter int IMAGE_WIDTH  = sbrs_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = sbrs_pkg::IMAGE_HEIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [15:0]          win_xy,
    input  sbrs_pkg::map_stage_t item,
    output logic [31:0]          rdata,
    output sbrs_pkg::pix_meta_t  meta
);
    import sbrs_pkg::*;

    logic [31:0] mem [0:MEM_DEPTH-1];
    logic [31:0] rdata_reg;
    pix_meta_t   meta_reg;
    logic [7:0]  u, v;
    logic [8:0]  px, py;
    logic [19:0] lin;
    logic        in_img;

    always_comb
    begin
        u      = item.odd ? item.qv : item.qu;
        v      = item.odd ? item.qu : item.qv;
        px     = 9'(win_xy[7:0]) + 9'(u);
        py     = 9'(win_xy[15:8]) + 9'(v);
        in_img = (px < 9'(IMAGE_WIDTH)) && (py < 9'(IMAGE_HEIGHT));
        lin    = 20'(py) * 20'(IMAGE_WIDTH) + 20'(px);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (item.valid && !item.kind)
            begin
                mem[item.load_address] <= item.load_color;
            end
            rdata_reg <= mem[lin[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_reg <= '0;
        end
        else if (adv)
        begin
            meta_reg.valid <= item.valid && item.kind;
            meta_reg.ok    <= item.ok && in_img;
            meta_reg.tx    <= item.tx;
            meta_reg.ty    <= item.ty;
        end
    end

    assign rdata = rdata_reg;
    assign meta  = meta_reg;

endmodule

### src/sprite_blit_rotate_scale.sv
// ----------------------------------------------------------------------------
// sprite_blit_rotate_scale
// Pipeline: after start is accepted, each item passes the input register,
// 8 divider stages, the memory read and the color stage. Throughput: one
// item per cycle while busy is low; a tinted pixel gives two writes on the
// output, and busy is high while the first of its two writes is on the ports.
// Reset: rst_n clears control and configuration; sprite memory is not cleared.
// ----------------------------------------------------------------------------
module sprite_blit_rotate_scale
#(
    parameter int IMAGE_WIDTH  = sbrs_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = sbrs_pkg::IMAGE_HEIGHT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [11:0]                    load_address,
    input  logic [31:0]                    load_color,
    input  logic signed [15:0]             dest_x,
    input  logic signed [15:0]             dest_y,
    input  logic [12:0]                    step_i,
    input  logic [12:0]                    step_j,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sbrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    output logic                           result_valid,
    output logic signed [16:0]             target_x,
    output logic signed [16:0]             target_y,
    output logic [31:0]                    pixel_color,
    output logic                           last
);
    import sbrs_pkg::*;

    logic [31:0]        window_reg;
    logic signed [15:0] scale_x_reg, scale_y_reg;
    logic [1:0]         turns_reg;
    logic               mono_reg;
    logic [8:0]         opacity_reg;
    logic [63:0]        palette_reg;
    logic [31:0]        tint_reg;

    logic               tint_pend_reg, result_valid_reg, last_reg;
    logic signed [16:0] tx_reg, ty_reg;
    logic [31:0]        color_reg;

    logic               adv, accept;
    geom_cfg_t          gcfg;
    map_stage_t         tail;
    pix_meta_t          meta;
    logic [31:0]        rdata, color;
    logic [8:0]         opa;
    logic [16:0]        prod;
    logic [7:0]         alpha;
    logic               tint;

    assign adv       = !tint_pend_reg;
    assign busy      = tint_pend_reg;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign gcfg.window  = window_reg;
    assign gcfg.scale_x = scale_x_reg;
    assign gcfg.scale_y = scale_y_reg;
    assign gcfg.turns   = turns_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RST;
            scale_x_reg <= SCALE_RST;
            scale_y_reg <= SCALE_RST;
            turns_reg   <= 2'd0;
            mono_reg    <= 1'b0;
            opacity_reg <= OPACITY_RST;
            palette_reg <= PALETTE_RST;
            tint_reg    <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW:  window_reg  <= cfg_data[31:0];
                REG_SCALE_X: scale_x_reg <= cfg_data[15:0];
                REG_SCALE_Y: scale_y_reg <= cfg_data[15:0];
                REG_TURNS:   turns_reg   <= cfg_data[1:0];
                REG_MONO:    mono_reg    <= cfg_data[0];
                REG_OPACITY: opacity_reg <= cfg_data[8:0];
                REG_PALETTE: palette_reg <= cfg_data;
                REG_TINT:    tint_reg    <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    sbrs_map u_map
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .accept       (accept),
        .kind         (kind),
        .load_address (load_address),
        .load_color   (load_color),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .step_i       (step_i),
        .step_j       (step_j),
        .cfg          (gcfg),
        .tail         (tail)
    );

    sbrs_mem
    #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    )
    u_mem
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .win_xy (window_reg[15:0]),
        .item   (tail),
        .rdata  (rdata),
        .meta   (meta)
    );

    always_comb
    begin
        alpha = rdata[31:24];
        opa   = opacity_reg[8] ? OPACITY_RST : opacity_reg;
        prod  = 17'(alpha) * 17'(opa);
        if (mono_reg)
        begin
            if (alpha < ALPHA_FULL || rdata[23:0] == 24'd0)
                color = palette_reg[31:0];
            else
                color = palette_reg[63:32];
        end
        else
        begin
            color = {prod[15:8], rdata[23:0]};
        end
        tint = (tint_reg != 32'd0) && (color != 32'd0) && (prod != 17'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_pend_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
        end
        else if (tint_pend_reg)
        begin
            tint_pend_reg    <= 1'b0;
            result_valid_reg <= 1'b1;
            last_reg         <= 1'b1;
        end
        else
        begin
            result_valid_reg <= meta.valid && meta.ok;
            tint_pend_reg    <= meta.valid && meta.ok && tint;
            last_reg         <= !tint;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tint_pend_reg)
        begin
            color_reg <= tint_reg;
        end
        else
        begin
            color_reg <= color;
            tx_reg    <= meta.tx;
            ty_reg    <= meta.ty;
        end
    end

    assign result_valid = result_valid_reg;
    assign target_x     = tx_reg;
    assign target_y     = ty_reg;
    assign pixel_color  = color_reg;
    assign last         = last_reg;

endmodule

### src/sbrs_checker.sv
// ----------------------------------------------------------------------------
// sbrs_checker
// Port-level checks on the tint write sequencing.
// ----------------------------------------------------------------------------
module sbrs_checker
(
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic result_valid,
    input logic last
);

    a_busy_on_first: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> result_valid && !last)
        else $error("busy without a pending tint write");

    a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held more than one cycle");

    a_tint_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid && last)
        else $error("tint write missing");

    a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final beat without busy");

endmodule

bind sprite_blit_rotate_scale sbrs_checker u_sbrs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .last         (last)
);

### dv/sprite_blit_rotate_scale_test.sv
// ----------------------------------------------------------------------------
// sprite_blit_rotate_scale_test
// Self-checking bench: loads sprite pixels, draws positions under several
// window, scale, rotation and color settings, and compares every write.
// ----------------------------------------------------------------------------
module sprite_blit_rotate_scale_test;
    import sbrs_pkg::*;

    typedef struct {
        logic signed [16:0] tx;
        logic signed [16:0] ty;
        logic [31:0]        color;
        logic               last;
    } blit_write_t;

    class blit_scoreboard;
        logic [31:0]        mem [MEM_DEPTH];
        bit                 written [MEM_DEPTH];
        logic [31:0]        window;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [1:0]         turns;
        logic               mono;
        logic [8:0]         opacity;
        logic [63:0]        palette;
        logic [31:0]        tint;
        blit_write_t        pending[$];
        int                 errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
            case (idx)
                REG_WINDOW:  window = d[31:0];
                REG_SCALE_X: sx = d[15:0];
                REG_SCALE_Y: sy = d[15:0];
                REG_TURNS:   turns = d[1:0];
                REG_MONO:    mono = d[0];
                REG_OPACITY: opacity = d[8:0];
                REG_PALETTE: palette = d;
                REG_TINT:    tint = d[31:0];
                default: ;
            endcase
        endfunction

        // memory address a draw reads, or -1 when it reads nothing
        function int read_addr(logic [12:0] si, logic [12:0] sj);
            int ax, ay, aw, ah, u, v, t, px, py;
            ax = sx < 0 ? -int'(sx) : int'(sx);
            ay = sy < 0 ? -int'(sy) : int'(sy);
            if (ax == 0 || ay == 0)
                return -1;
            aw = (int'(window[23:16]) * ax) >>> 8;
            ah = (int'(window[31:24]) * ay) >>> 8;
            if (turns[0])
            begin
                t = aw; aw = ah; ah = t;
            end
            if (int'(si) >= aw || int'(sj) >= ah)
                return -1;
            u = (int'(si) * 256) / ax;
            v = (int'(sj) * 256) / ay;
            if (turns[0])
            begin
                t = u; u = v; v = t;
            end
            px = int'(window[7:0]) + u;
            py = int'(window[15:8]) + v;
            if (px >= 64 || py >= 64)
                return -1;
            return (py * 64 + px) % MEM_DEPTH;
        endfunction

        function void note_beat(logic k, logic [11:0] la, logic [31:0] lc,
                                logic signed [15:0] dx, logic signed [15:0] dy,
                                logic [12:0] si, logic [12:0] sj);
            int ax, ay, aw, ah, u, v, t, tx, ty, px, py, al, opa;
            logic [31:0] pix, col;
            logic odd, fx, dotint;
            blit_write_t w;
            if (!k)
            begin
                mem[la] = lc;
                written[la] = 1'b1;
                return;
            end
            ax = sx < 0 ? -int'(sx) : int'(sx);
            ay = sy < 0 ? -int'(sy) : int'(sy);
            if (ax == 0 || ay == 0)
                return;
            odd = turns[0];
            aw = (int'(window[23:16]) * ax) >>> 8;
            ah = (int'(window[31:24]) * ay) >>> 8;
            if (odd)
            begin
                t = aw; aw = ah; ah = t;
            end
            if (int'(si) >= aw || int'(sj) >= ah)
                return;
            u = (int'(si) * 256) / ax;
            v = (int'(sj) * 256) / ay;
            if (odd)
            begin
                t = u; u = v; v = t;
            end
            tx = int'(dx) + int'(si);
            ty = int'(dy) + int'(sj);
            if ((sy > 0 && turns >= 2) || (sy < 0 && turns < 2))
                ty = int'(dy) + ah - 1 - int'(sj);
            fx = (turns == 1 || turns == 2);
            if ((sx < 0 && !fx) || (sx > 0 && fx))
                tx = int'(dx) + aw - 1 - int'(si);
            px = int'(window[7:0]) + u;
            py = int'(window[15:8]) + v;
            if (px >= 64 || py >= 64)
                return;
            pix = mem[(py * 64 + px) % MEM_DEPTH];
            al = int'(pix[31:24]);
            opa = opacity > 256 ? 256 : int'(opacity);
            if (mono)
                col = (al < 255 || pix[23:0] == 0) ? palette[31:0] : palette[63:32];
            else
                col = {8'((al * opa) >> 8), pix[23:0]};
            dotint = tint != 0 && col != 0 && al * opa != 0;
            w.tx = 17'(tx);
            w.ty = 17'(ty);
            w.color = col;
            w.last = !dotint;
            pending.push_back(w);
            if (dotint)
            begin
                w.color = tint;
                w.last = 1'b1;
                pending.push_back(w);
            end
        endfunction

        function void check_beat(blit_write_t got);
            blit_write_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected write x=%0d y=%0d c=%h", $time,
                         got.tx, got.ty, got.color);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.tx !== e.tx)
            begin
                $display("%0t target_x exp %0d got %0d", $time, e.tx, got.tx);
                errors++;
            end
            if (got.ty !== e.ty)
            begin
                $display("%0t target_y exp %0d got %0d", $time, e.ty, got.ty);
                errors++;
            end
            if (got.color !== e.color)
            begin
                $display("%0t pixel_color exp %h got %h", $time, e.color, got.color);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $display("%0t last exp %b got %b", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 kind;
    logic [11:0]          load_address;
    logic [31:0]          load_color;
    logic signed [15:0]   dest_x;
    logic signed [15:0]   dest_y;
    logic [12:0]          step_i;
    logic [12:0]          step_j;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 result_valid;
    logic signed [16:0]   target_x;
    logic signed [16:0]   target_y;
    logic [31:0]          pixel_color;
    logic                 last;

    blit_scoreboard sb;
    int             gap_pct;
    int             quiet_cycles;

    sprite_blit_rotate_scale i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .load_address (load_address),
        .load_color   (load_color),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .step_i       (step_i),
        .step_j       (step_j),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .target_x     (target_x),
        .target_y     (target_y),
        .pixel_color  (pixel_color),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        blit_write_t got;
        if (rst_n && result_valid)
        begin
            got.tx = target_x;
            got.ty = target_y;
            got.color = pixel_color;
            got.last = last;
            sb.check_beat(got);
        end
        if (rst_n && ((start && !busy) || result_valid || (cfg_valid && cfg_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 5000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_pixel();
        logic [31:0] c;
        case ($urandom_range(3))
            0: c = 32'hFF00_0000 | 32'($urandom_range(1));
            1: c = {8'hFF, 24'($urandom)};
            2: c = {8'h00, 24'($urandom)};
            default: c = $urandom;
        endcase
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
        @(negedge clk);
        start     <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one beat; start stays high across back-to-back beats, drain and
    // write_reg drop it
    task automatic send_beat(logic k, logic [11:0] la, logic [31:0] lc,
                             logic signed [15:0] dx, logic signed [15:0] dy,
                             logic [12:0] si, logic [12:0] sj);
        int ra;
        if (k)
        begin
            ra = sb.read_addr(si, sj);
            if (ra >= 0 && !sb.written[ra])
                load_pixel(12'(ra), rand_pixel());
        end
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        load_address <= la;
        load_color   <= lc;
        dest_x       <= dx;
        dest_y       <= dy;
        step_i       <= si;
        step_j       <= sj;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_beat(k, la, lc, dx, dy, si, sj);
    endtask

    task automatic load_pixel(logic [11:0] a, logic [31:0] c);
        send_beat(1'b0, a, c, 16'($urandom), 16'($urandom), 13'($urandom),
                  13'($urandom));
    endtask

    task automatic drain();
        int n;
        n = 0;
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(negedge clk);
    endtask

    // mostly inside the drawn area, now and then anywhere
    task automatic random_draw();
        logic [12:0] si, sj;
        int ax, ay, aw, ah;
        ax = sb.sx < 0 ? -int'(sb.sx) : int'(sb.sx);
        ay = sb.sy < 0 ? -int'(sb.sy) : int'(sb.sy);
        aw = (int'(sb.window[23:16]) * ax) >>> 8;
        ah = (int'(sb.window[31:24]) * ay) >>> 8;
        if (sb.turns[0])
        begin
            int t;
            t = aw; aw = ah; ah = t;
        end
        if ($urandom_range(9) == 0 || aw == 0 || ah == 0)
        begin
            si = 13'($urandom_range(8191));
            sj = 13'($urandom_range(8191));
        end
        else
        begin
            si = 13'($urandom_range(aw + 1));
            sj = 13'($urandom_range(ah + 1));
        end
        send_beat(1'b1, 12'($urandom), 32'($urandom), 16'($urandom), 16'($urandom),
                  si, sj);
    endtask

    task automatic random_setup(int mode);
        write_reg(REG_WINDOW, {32'h0, 8'($urandom_range(60, 70)), 8'($urandom_range(60, 70)),
                               8'($urandom_range(1, 20)), 8'($urandom_range(1, 20))});
        write_reg(REG_SCALE_X, 64'(16'($urandom_range(0, 3) == 0 ? -int'($urandom_range(64, 800))
                                                                 : $urandom_range(64, 800))));
        write_reg(REG_SCALE_Y, 64'(16'($urandom_range(0, 3) == 0 ? -int'($urandom_range(64, 800))
                                                                 : $urandom_range(64, 800))));
        write_reg(REG_TURNS, 64'($urandom_range(3)));
        write_reg(REG_MONO, 64'(mode & 1));
        write_reg(REG_OPACITY, 64'($urandom_range(511)));
        write_reg(REG_PALETTE, {$urandom, $urandom});
        write_reg(REG_TINT, (mode & 2) ? 64'($urandom) : 64'h0);
    endtask

    initial
    begin
        sb = new();
        sb.set_reg(REG_WINDOW, 64'(WINDOW_RST));
        sb.set_reg(REG_SCALE_X, 64'(SCALE_RST));
        sb.set_reg(REG_SCALE_Y, 64'(SCALE_RST));
        sb.set_reg(REG_TURNS, 64'h0);
        sb.set_reg(REG_MONO, 64'h0);
        sb.set_reg(REG_OPACITY, 64'(OPACITY_RST));
        sb.set_reg(REG_PALETTE, PALETTE_RST);
        sb.set_reg(REG_TINT, 64'h0);
        sb.errors = 0;
        quiet_cycles = 0;
        gap_pct = 9;
        rst_n = 1'b0;
        start = 1'b0;
        kind = 1'b0;
        load_address = '0;
        load_color = '0;
        dest_x = '0;
        dest_y = '0;
        step_i = '0;
        step_j = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corners, mirrors, turns, zero scale, outside image, opacity
        load_pixel(12'd0, 32'hFFFF_FFFF);
        load_pixel(12'd4095, 32'h8012_3456);
        send_beat(1'b1, 0, 0, 16'sh7FFF, 16'sh8000, 13'd0, 13'd0);
        send_beat(1'b1, 0, 0, 16'sh8000, 16'sh7FFF, 13'd63, 13'd63);
        send_beat(1'b1, 0, 0, 16'sd0, 16'sd0, 13'd64, 13'd0);
        send_beat(1'b1, 0, 0, 16'sd0, 16'sd0, 13'h1FFF, 13'h1FFF);
        drain();
        write_reg(REG_TINT, 64'hFFFF_FFFF);
        write_reg(REG_OPACITY, 64'd511);
        write_reg(REG_SCALE_X, 64'hFFFF_FF00);
        send_beat(1'b1, 0, 0, 16'sd5, 16'sd5, 13'd0, 13'd0);
        send_beat(1'b1, 0, 0, 16'sd5, 16'sd5, 13'd63, 13'd1);
        drain();
        for (int q = 0; q < 4; q++)
        begin
            write_reg(REG_TURNS, 64'(q));
            write_reg(REG_SCALE_Y, q[0] ? 64'hFFFF_FF80 : 64'h0000_0200);
            send_beat(1'b1, 0, 0, 16'sd1, 16'sd2, 13'd3, 13'd7);
            send_beat(1'b1, 0, 0, 16'sd1, 16'sd2, 13'd0, 13'd0);
            drain();
        end
        write_reg(REG_WINDOW, 64'hFFFF_FFFF);
        write_reg(REG_SCALE_Y, 64'h7FFF);
        write_reg(REG_SCALE_X, 64'h8000);
        send_beat(1'b1, 0, 0, 16'sd0, 16'sd0, 13'd0, 13'd0);
        drain();
        write_reg(REG_SCALE_X, 64'h0);
        write_reg(REG_MONO, 64'h1);
        write_reg(REG_OPACITY, 64'h0);
        write_reg(REG_PALETTE, 64'h0);
        send_beat(1'b1, 0, 0, 16'sd0, 16'sd0, 13'd0, 13'd0);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = ph == 0 ? 9 : (ph == 1 ? 84 : 0);
            for (int k = 0; k < 4; k++)
            begin
                random_setup(k);
                for (int n = 0; n < 18; n++)
                    if ($urandom_range(9) == 0)
                        load_pixel(12'($urandom), rand_pixel());
                    else
                        random_draw();
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### sim.f
src/sbrs_pkg.sv
src/sbrs_map.sv
src/sbrs_mem.sv
src/sprite_blit_rotate_scale.sv
src/sbrs_checker.sv
dv/sprite_blit_rotate_scale_test.sv
